FILE: src/pulse_dial_digit_decoder_core_defines.svh
// Assertion macros shared by the pulse dial decoder RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PULSE_DIAL_DIGIT_DECODER_CORE_DEFINES_SVH
`define PULSE_DIAL_DIGIT_DECODER_CORE_DEFINES_SVH

// Check that is suspended while reset is high.
`define PDDD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that is evaluated at every edge, reset included.
`define PDDD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/pddd_pkg.sv
// Types and constants of the pulse dial digit decoder.
// Used by pddd_step and pulse_dial_digit_decoder_core; depends on nothing.
`default_nettype none

package pddd_pkg;

   localparam int TIME_W  = 16;
   localparam int TALLY_W = 4;
   localparam int COUNT_W = 5;

   typedef enum logic [2:0] {
      PH_ON_HOOK   = 3'd0,
      PH_OFF_HOOK  = 3'd1,
      PH_DIALING   = 3'd2,
      PH_GOT_PULSE = 3'd3,
      PH_COMPLETED = 3'd4
   } phase_type;

   // Configuration register indexes.
   localparam logic [7:0] REG_DEBOUNCE = 8'd0;
   localparam logic [7:0] REG_ON_HOOK  = 8'd1;
   localparam logic [7:0] REG_GAP      = 8'd2;
   localparam logic [7:0] REG_DIGITS   = 8'd3;

   localparam logic [TALLY_W-1:0] PULSE_MAX  = 4'd10;
   localparam logic [TALLY_W-1:0] PULSE_SAT  = 4'd15;
   localparam logic [COUNT_W-1:0] DIGITS_MAX = 5'd16;

   typedef struct packed {
      logic [TIME_W-1:0]  debounce_ms;
      logic [TIME_W-1:0]  on_hook_ms;
      logic [TIME_W-1:0]  digit_gap_ms;
      logic [COUNT_W-1:0] digits_wanted;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]  change_time;
      logic               stable_level;
      phase_type          phase;
      logic [TALLY_W-1:0] pulse_tally;
      logic [COUNT_W-1:0] digit_tally;
   } state_type;

   typedef struct packed {
      logic [2:0]         line_state;
      logic               digit_valid;
      logic [3:0]         digit_value;
      logic [3:0]         digit_position;
      logic [COUNT_W-1:0] digits_stored;
   } result_type;

   localparam cfg_type CFG_RESET = '{
      debounce_ms:   16'd15,
      on_hook_ms:    16'd500,
      digit_gap_ms:  16'd300,
      digits_wanted: 5'd10
   };

   localparam state_type STATE_RESET = '{
      change_time:  16'd0,
      stable_level: 1'b1,
      phase:        PH_ON_HOOK,
      pulse_tally:  4'd0,
      digit_tally:  5'd0
   };

endpackage

`default_nettype wire

FILE: src/pddd_step.sv
// Next-state and result logic for one poll of the line-sense pin.
// Purely combinational; uses types and constants from pddd_pkg.
`default_nettype none

module pddd_step (
   input  wire logic                          level,
   input  wire logic [pddd_pkg::TIME_W-1:0]   now_ms,
   input  wire pddd_pkg::cfg_type             cfg,
   input  wire pddd_pkg::state_type           cur,
   output pddd_pkg::state_type                nxt,
   output pddd_pkg::result_type               res
);

   logic [pddd_pkg::TIME_W-1:0]  elapsed_raw;
   logic [pddd_pkg::TIME_W-1:0]  elapsed;
   logic                         changed;
   logic [pddd_pkg::COUNT_W-1:0] want;

   assign elapsed_raw = now_ms - cur.change_time;
   assign changed     = level != cur.stable_level;
   assign elapsed     = changed ? '0 : elapsed_raw;

   always_comb begin
      if (cfg.digits_wanted == '0) begin
         want = pddd_pkg::COUNT_W'(1);
      end else if (cfg.digits_wanted > pddd_pkg::DIGITS_MAX) begin
         want = pddd_pkg::DIGITS_MAX;
      end else begin
         want = cfg.digits_wanted;
      end
   end

   always_comb begin
      nxt = cur;
      res = '0;
      if (cur.change_time == '0) begin
         // Not started yet: the poll only records the time.
         nxt.change_time = now_ms;
      end else if (!(changed && elapsed_raw < cfg.debounce_ms)) begin
         if (changed) begin
            nxt.change_time  = now_ms;
            nxt.stable_level = level;
         end
         if (level) begin
            case (cur.phase)
               pddd_pkg::PH_OFF_HOOK: begin
                  nxt.phase       = pddd_pkg::PH_DIALING;
                  nxt.digit_tally = '0;
                  nxt.pulse_tally = '0;
               end
               pddd_pkg::PH_DIALING: begin
                  nxt.phase = (elapsed >= cfg.on_hook_ms) ? pddd_pkg::PH_ON_HOOK
                                                          : pddd_pkg::PH_GOT_PULSE;
               end
               pddd_pkg::PH_GOT_PULSE, pddd_pkg::PH_COMPLETED: begin
                  if (elapsed >= cfg.on_hook_ms) begin
                     nxt.phase = pddd_pkg::PH_ON_HOOK;
                  end
               end
               default: begin
               end
            endcase
         end else begin
            case (cur.phase)
               pddd_pkg::PH_ON_HOOK: begin
                  nxt.phase       = pddd_pkg::PH_OFF_HOOK;
                  nxt.digit_tally = '0;
               end
               pddd_pkg::PH_GOT_PULSE: begin
                  if (cur.pulse_tally != pddd_pkg::PULSE_SAT) begin
                     nxt.pulse_tally = cur.pulse_tally + 1'b1;
                  end
                  nxt.phase = pddd_pkg::PH_DIALING;
               end
               pddd_pkg::PH_DIALING: begin
                  if (elapsed >= cfg.digit_gap_ms && cur.pulse_tally != '0) begin
                     // Counts above ten end the digit without storing it.
                     if (cur.digit_tally < want && cur.pulse_tally <= pddd_pkg::PULSE_MAX) begin
                        res.digit_valid    = 1'b1;
                        res.digit_value    = (cur.pulse_tally == pddd_pkg::PULSE_MAX) ?
                                             4'd0 : cur.pulse_tally;
                        res.digit_position = cur.digit_tally[3:0];
                        nxt.digit_tally    = cur.digit_tally + 1'b1;
                     end
                     if (nxt.digit_tally == want) begin
                        nxt.phase = pddd_pkg::PH_COMPLETED;
                     end
                     nxt.pulse_tally = '0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      res.line_state    = nxt.phase;
      res.digits_stored = nxt.digit_tally;
   end

endmodule

`default_nettype wire

FILE: src/pulse_dial_digit_decoder_core.sv
// Rotary pulse dial decoder: debounces line-sense polls and emits dialed digits.
// A taken poll moves from the input register into the result register (rsp_ ports).
// Throughput: one poll per cycle unless rsp_ready stalls; the input register and the
// result register are the only stages, and line state updates as a poll moves into it.
// Reset (synchronous, active high) restores register defaults and the on-hook state.
`default_nettype none

`include "pulse_dial_digit_decoder_core_defines.svh"

module pulse_dial_digit_decoder_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_line_level,
   input  wire logic [pddd_pkg::TIME_W-1:0]        req_now_ms,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [2:0]                              rsp_line_state,
   output logic                                    rsp_digit_valid,
   output logic [3:0]                              rsp_digit_value,
   output logic [3:0]                              rsp_digit_position,
   output logic [pddd_pkg::COUNT_W-1:0]            rsp_digits_stored,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [7:0]                         csr_index,
   input  wire logic [pddd_pkg::TIME_W-1:0]        csr_data
);

   pddd_pkg::cfg_type    cfg_ff, cfg_in;
   pddd_pkg::state_type  state_ff, state_in, state_nxt;
   pddd_pkg::result_type rsp_ff, rsp_in, step_res;

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_level_ff, s1_level_in;
   logic [pddd_pkg::TIME_W-1:0] s1_now_ff, s1_now_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        s1_move;
   logic                        req_xfer;

   pddd_step u_step (
      .level  (s1_level_ff),
      .now_ms (s1_now_ff),
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .nxt    (state_nxt),
      .res    (step_res)
   );

   // The held poll moves on whenever the result register is empty or being drained.
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      s1_valid_in  = req_xfer ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s1_level_in  = req_xfer ? req_line_level : s1_level_ff;
      s1_now_in    = req_xfer ? req_now_ms : s1_now_ff;
      rsp_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = s1_move ? step_res : rsp_ff;
      state_in     = s1_move ? state_nxt : state_ff;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pddd_pkg::REG_DEBOUNCE: cfg_in.debounce_ms   = csr_data;
            pddd_pkg::REG_ON_HOOK:  cfg_in.on_hook_ms    = csr_data;
            pddd_pkg::REG_GAP:      cfg_in.digit_gap_ms  = csr_data;
            pddd_pkg::REG_DIGITS:   cfg_in.digits_wanted = csr_data[pddd_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= pddd_pkg::CFG_RESET;
         state_ff     <= pddd_pkg::STATE_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_level_ff <= s1_level_in;
      s1_now_ff   <= s1_now_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_state     = rsp_ff.line_state;
   assign rsp_digit_valid    = rsp_ff.digit_valid;
   assign rsp_digit_value    = rsp_ff.digit_value;
   assign rsp_digit_position = rsp_ff.digit_position;
   assign rsp_digits_stored  = rsp_ff.digits_stored;

   `PDDD_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid_ff && !s1_valid_ff && state_ff.phase == pddd_pkg::PH_ON_HOOK), "reset did not return to on hook")
   `PDDD_ASSERT(a_digit_legal, clock, reset, (rsp_valid_ff && rsp_ff.digit_valid) |-> (rsp_ff.digit_value <= 4'd9 && {1'b0, rsp_ff.digit_position} + 5'd1 == rsp_ff.digits_stored), "stored digit inconsistent with count")
   `PDDD_ASSERT(a_tally_bound, clock, reset, state_ff.digit_tally <= pddd_pkg::DIGITS_MAX, "digit count beyond sixteen")
   `PDDD_ASSERT(a_state_hold, clock, reset, !s1_move |=> $stable(state_ff), "line state changed without a poll")
   `PDDD_ASSERT(a_poll_kept, clock, reset, (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(s1_now_ff)), "held poll lost before transfer")

endmodule

`default_nettype wire
